@@ design/qbf_pkg.sv @@
`timescale 1ns / 1ps
package qbf_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_EDGES   = 4096;
  localparam int NODE_W      = 10;
  localparam int EDGE_W      = 12;
  localparam int COUNT_W     = 11;
  localparam int ROW_W       = 13;
  localparam int DIST_W      = 48;
  localparam int WEIGHT_BITS = 32;

  localparam logic [1:0] CMD_LOAD_ROW  = 2'd0;
  localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
  localparam logic [1:0] CMD_RUN       = 2'd2;
  localparam logic [1:0] CMD_READ      = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NEG_CYC = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [11:0]             index;
    logic [12:0]             value;
    logic signed [31:0]      weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [47:0]      distance;
    logic                    reachable;
    logic [9:0]              parent_node;
    logic                    has_parent;
  } out_item_t;

  // Per-node bookkeeping kept together in one memory word.
  typedef struct packed {
    logic                    reached;
    logic                    parent_valid;
    logic                    in_queue;
    logic [COUNT_W-1:0]      enq_count;
  } node_stat_t;

endpackage

@@ design/queue_bellman_ford_sssp_top.sv @@
`timescale 1ns / 1ps
// Queue-driven shortest path engine over a graph in compressed-row form.
// Input channel (in_valid/in_ready/in_item) carries commands: load row start,
// load edge, run from a source node, read a node. Every item yields exactly
// one result item on the output channel (out_valid/out_ready/out_item).
// Loads answer in the cycle after acceptance; a read passes through S_READ
// before its result is registered. A run first sweeps all 1024 entries of the
// node state memory, then pops nodes from a ring and relaxes each outgoing
// edge; a popped node passes S_POP, S_U, S_LO and S_HI, each edge S_EDGE, S_ER
// and, for an in-range destination, S_REL, where the node memories are updated.
// The block works on one item at a time: in_ready is high only when the
// engine is idle and the output register is empty or being emptied, so an
// item can follow a load result back to back. The output register holds its
// item while out_ready is low.
// After reset a pass clears all 1024 entries of the node state memory, during
// which no item is accepted. num_nodes is written through cfg_wen/cfg_wdata
// and resets to one.
module queue_bellman_ford_sssp_top
  import qbf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_item
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_POP  = 4'd3;
  localparam logic [3:0] S_U    = 4'd4;
  localparam logic [3:0] S_LO   = 4'd5;
  localparam logic [3:0] S_HI   = 4'd6;
  localparam logic [3:0] S_EDGE = 4'd7;
  localparam logic [3:0] S_ER   = 4'd8;
  localparam logic [3:0] S_REL  = 4'd9;
  localparam logic [3:0] S_READ = 4'd10;

  logic [3:0]          state;
  logic [10:0]         num_nodes;
  logic [COUNT_W-1:0]  n_eff;
  logic [NODE_W-1:0]   clr_addr;
  logic                run_pending;
  logic [NODE_W-1:0]   src;
  logic [NODE_W-1:0]   u;
  logic [NODE_W-1:0]   v;
  logic signed [DIST_W-1:0] du;
  logic signed [WEIGHT_BITS-1:0] w;
  logic [ROW_W-1:0]    e;
  logic [ROW_W-1:0]    hi;
  logic [NODE_W-1:0]   ring_head;
  logic [NODE_W-1:0]   ring_tail;
  logic [COUNT_W-1:0]  ring_count;

  // Memories.
  logic [ROW_W-1:0]    row_mem    [MAX_NODES+1];
  logic [NODE_W-1:0]   dest_mem   [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] wt_mem  [MAX_EDGES];
  logic [DIST_W-1:0]   dist_mem   [MAX_NODES];
  logic [NODE_W-1:0]   par_mem    [MAX_NODES];
  node_stat_t          stat_mem   [MAX_NODES];
  logic [NODE_W-1:0]   ring_mem   [MAX_NODES];

  logic [ROW_W-1:0]    row_q;
  logic [NODE_W-1:0]   dest_q;
  logic [WEIGHT_BITS-1:0] wt_q;
  logic [DIST_W-1:0]   dist_q;
  logic [NODE_W-1:0]   par_q;
  node_stat_t          stat_q;
  logic [NODE_W-1:0]   ring_q;

  logic                row_we;
  logic [10:0]         row_wa;
  logic [10:0]         row_ra;
  logic                edge_we;
  logic [EDGE_W-1:0]   edge_a;
  logic                dist_we;
  logic [NODE_W-1:0]   dist_wa;
  logic [DIST_W-1:0]   dist_wd;
  logic [NODE_W-1:0]   node_ra;
  logic                par_we;
  logic                stat_we;
  logic [NODE_W-1:0]   stat_wa;
  node_stat_t          stat_wd;
  logic                ring_we;
  logic [NODE_W-1:0]   ring_wd;

  logic                accept;
  logic signed [DIST_W:0] sum;
  logic signed [DIST_W-1:0] cand;
  logic                improve;
  logic                need_push;
  logic                neg_cycle;
  logic                res_load;
  out_item_t           res_item;

  assign n_eff = (num_nodes == 11'd0) ? COUNT_W'(1) :
                 (num_nodes > 11'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : num_nodes;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Relaxation arithmetic with saturation to the 48-bit range.
  assign sum = {du[DIST_W-1], du} + {{(DIST_W+1-WEIGHT_BITS){w[WEIGHT_BITS-1]}}, w};
  always_comb begin
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end
  assign improve   = !stat_q.reached || (cand < $signed(dist_q));
  assign need_push = improve && !stat_q.in_queue;
  assign neg_cycle = need_push && (stat_q.enq_count >= n_eff);

  // Memory port control.
  always_comb begin
    row_we  = 1'b0;
    row_wa  = in_item.index[10:0];
    row_ra  = {1'b0, u};
    edge_we = 1'b0;
    edge_a  = e[EDGE_W-1:0];
    dist_we = 1'b0;
    dist_wa = v;
    dist_wd = cand;
    node_ra = v;
    par_we  = 1'b0;
    stat_we = 1'b0;
    stat_wa = v;
    stat_wd = '0;
    ring_we = 1'b0;
    ring_wd = v;
    case (state)
      S_IDLE: begin
        edge_a  = in_item.index;
        node_ra = in_item.index[NODE_W-1:0];
        if (accept && in_item.cmd == CMD_LOAD_ROW && in_item.index <= 12'(MAX_NODES)) begin
          row_we = 1'b1;
        end
        if (accept && in_item.cmd == CMD_LOAD_EDGE && in_item.value < 13'(MAX_NODES)) begin
          edge_we = 1'b1;
        end
      end
      S_CLR: begin
        stat_we = 1'b1;
        stat_wa = clr_addr;
      end
      S_INIT: begin
        dist_we = 1'b1;
        dist_wa = src;
        dist_wd = '0;
        stat_we = 1'b1;
        stat_wa = src;
        stat_wd = '{reached: 1'b1, parent_valid: 1'b0, in_queue: 1'b1,
                    enq_count: COUNT_W'(1)};
        ring_we = 1'b1;
        ring_wd = src;
      end
      S_U: begin
        row_ra  = {1'b0, ring_q};
        node_ra = ring_q;
      end
      S_LO: begin
        row_ra  = 11'({1'b0, u} + 11'd1);
        stat_we = 1'b1;
        stat_wa = u;
        stat_wd = stat_q;
        stat_wd.in_queue = 1'b0;
      end
      S_ER: begin
        // The destination's state is read while its index is registered.
        node_ra = dest_q;
      end
      S_REL: begin
        if (improve) begin
          dist_we = 1'b1;
          par_we  = 1'b1;
          stat_we = 1'b1;
          stat_wd = stat_q;
          stat_wd.reached = 1'b1;
          stat_wd.parent_valid = 1'b1;
          if (need_push && !neg_cycle) begin
            stat_wd.in_queue  = 1'b1;
            stat_wd.enq_count = stat_q.enq_count + COUNT_W'(1);
            ring_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_wa] <= in_item.value;
    row_q <= row_mem[row_ra];
    if (edge_we) begin
      dest_mem[edge_a] <= in_item.value[NODE_W-1:0];
      wt_mem[edge_a]   <= in_item.weight;
    end
    dest_q <= dest_mem[edge_a];
    wt_q   <= wt_mem[edge_a];
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_q <= dist_mem[node_ra];
    if (par_we) par_mem[v] <= u;
    par_q <= par_mem[node_ra];
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    stat_q <= stat_mem[node_ra];
    if (ring_we) ring_mem[ring_tail] <= ring_wd;
    ring_q <= ring_mem[ring_head];
  end

  // Result item produced in this cycle, if any.
  always_comb begin
    res_load = 1'b0;
    res_item = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_item.cmd)
            CMD_LOAD_ROW: begin
              res_load = 1'b1;
              if (in_item.index > 12'(MAX_NODES)) res_item.status = STATUS_RANGE;
            end
            CMD_LOAD_EDGE: begin
              res_load = 1'b1;
              if (in_item.value >= 13'(MAX_NODES)) res_item.status = STATUS_RANGE;
            end
            default: begin
              if (in_item.index >= 12'(n_eff)) begin
                res_load = 1'b1;
                res_item.status = STATUS_RANGE;
              end
            end
          endcase
        end
      end
      S_READ: begin
        res_load = 1'b1;
        res_item.reachable   = stat_q.reached;
        res_item.has_parent  = stat_q.parent_valid;
        res_item.distance    = stat_q.reached ? $signed(dist_q) : '0;
        res_item.parent_node = stat_q.parent_valid ? par_q : '0;
      end
      S_POP: begin
        if (ring_count == '0) begin
          res_load = 1'b1;
          res_item.status = STATUS_OK;
        end
      end
      S_REL: begin
        if (neg_cycle) begin
          res_load = 1'b1;
          res_item.status = STATUS_NEG_CYC;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_load) out_item <= res_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      num_nodes   <= 11'd1;
      clr_addr    <= '0;
      run_pending <= 1'b0;
      ring_head   <= '0;
      ring_tail   <= '0;
      ring_count  <= '0;
    end else begin
      if (cfg_wen) num_nodes <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (accept && in_item.cmd == CMD_RUN && in_item.index < 12'(n_eff)) begin
            src         <= in_item.index[NODE_W-1:0];
            run_pending <= 1'b1;
            clr_addr    <= '0;
            ring_tail   <= '0;
            state       <= S_CLR;
          end else if (accept && in_item.cmd == CMD_READ &&
                       in_item.index < 12'(n_eff)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        S_CLR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_addr == NODE_W'(MAX_NODES - 1)) begin
            state <= run_pending ? S_INIT : S_IDLE;
          end
        end
        S_INIT: begin
          run_pending <= 1'b0;
          ring_head   <= '0;
          ring_tail   <= NODE_W'(1);
          ring_count  <= COUNT_W'(1);
          state       <= S_POP;
        end
        S_POP: begin
          if (ring_count == '0) begin
            state <= S_IDLE;
          end else begin
            ring_head  <= ring_head + NODE_W'(1);
            ring_count <= ring_count - COUNT_W'(1);
            state      <= S_U;
          end
        end
        S_U: begin
          u     <= ring_q;
          state <= S_LO;
        end
        S_LO: begin
          e     <= row_q;
          du    <= $signed(dist_q);
          state <= S_HI;
        end
        S_HI: begin
          hi    <= (row_q > ROW_W'(MAX_EDGES)) ? ROW_W'(MAX_EDGES) : row_q;
          state <= S_EDGE;
        end
        S_EDGE: begin
          state <= (e < hi) ? S_ER : S_POP;
        end
        S_ER: begin
          v <= dest_q;
          w <= $signed(wt_q);
          if ({1'b0, dest_q} >= n_eff) begin
            e     <= e + ROW_W'(1);
            state <= S_EDGE;
          end else begin
            state <= S_REL;
          end
        end
        S_REL: begin
          e     <= e + ROW_W'(1);
          state <= neg_cycle ? S_IDLE : S_EDGE;
          if (improve) begin
            // A self loop changes the popped node's own distance.
            if (v == u) du <= cand;
            if (need_push && !neg_cycle) begin
              ring_tail  <= ring_tail + NODE_W'(1);
              ring_count <= ring_count + COUNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= COUNT_W'(MAX_NODES))
    else $error("ring occupancy exceeds node count");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == S_IDLE) && !run_pending)
    else $error("item accepted while engine busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == S_CLR) && (clr_addr == '0) && !out_valid)
    else $error("reset does not start the clearing pass");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    ring_we && (state == S_REL) |-> ring_count < COUNT_W'(MAX_NODES))
    else $error("push into a full ring");

endmodule
